// ----- rtl/xor_cipher_rotating_key_defines.svh -----
// Assertion macros for the rotating-key XOR cipher.
`ifndef XOR_CIPHER_ROTATING_KEY_DEFINES_SVH
`define XOR_CIPHER_ROTATING_KEY_DEFINES_SVH

`ifndef SYNTHESIS
`define XCRK_ASSERT_CLK(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("xcrk assertion failed");
`define XCRK_ASSERT(lbl, prop) `XCRK_ASSERT_CLK(lbl, clk_i, rst_ni, prop)
`else
`define XCRK_ASSERT_CLK(lbl, clk, rstn, prop)
`define XCRK_ASSERT(lbl, prop)
`endif

`endif

// ----- rtl/xcrk_pkg.sv -----
// Package with constants and types of the rotating-key XOR cipher.
`timescale 1ns / 1ps
package xcrk_pkg;

  localparam int unsigned BYTE_W            = 8;
  localparam int unsigned CFG_DATA_W        = 64;
  localparam int unsigned KEY_BYTES_W       = 4;
  localparam int unsigned DEF_MAX_KEY_BYTES = 8;

  localparam logic [BYTE_W-1:0]      BYTE_MASK     = 8'hFF;
  localparam logic [KEY_BYTES_W-1:0] KEY_BYTES_RST = 4'd8;

  typedef enum logic [0:0] {
    REG_KEY_VALUE = 1'b0,
    REG_KEY_BYTES = 1'b1
  } cfg_reg_e;

endpackage

// ----- rtl/xor_cipher_rotating_key.sv -----
// Output: the result of an accepted byte is held in a registered output stage.
// Throughput: one byte per cycle while the output is not stalled by m_axis_tready;
// the output register and the running-key update both complete in the accepting cycle, so requests follow back to back.
// Reset: key_value 0, key_bytes 8, running key 0, position 0, output empty.
// Config writes take effect at the edge of the write enable.
`timescale 1ns / 1ps
`include "xor_cipher_rotating_key_defines.svh"

module xor_cipher_rotating_key
  import xcrk_pkg::*;
#(
  parameter int unsigned MAX_KEY_BYTES = DEF_MAX_KEY_BYTES
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,

  input  logic                  cfg_we_i,
  input  logic                  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,

  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [BYTE_W-1:0]     s_axis_tdata,   // [7:0] plain_byte
  input  logic                  s_axis_tuser,   // [0] first_of_message
  input  logic                  s_axis_tlast,

  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [BYTE_W-1:0]     m_axis_tdata,   // [7:0] cipher_byte
  output logic                  m_axis_tlast
);

  localparam int unsigned KeyW = BYTE_W * MAX_KEY_BYTES;
  localparam int unsigned PosW = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
  localparam logic [KEY_BYTES_W-1:0] MaxLen = KEY_BYTES_W'(MAX_KEY_BYTES);
  localparam logic [KEY_BYTES_W-1:0] OneLen = KEY_BYTES_W'(1);

  logic [KeyW-1:0]        key_value_q;
  logic [KEY_BYTES_W-1:0] key_bytes_q;
  logic [KeyW-1:0]        running_key_q, running_key_d;
  logic [PosW-1:0]        pos_q, pos_d;
  logic                   out_valid_q;
  logic [BYTE_W-1:0]      out_data_q, out_data_d;
  logic                   out_last_q;

  logic                   s_hs;
  logic [KEY_BYTES_W-1:0] len_eff;
  logic [KeyW-1:0]        len_mask;
  logic [KeyW-1:0]        cur_key;
  logic [PosW-1:0]        cur_pos;
  logic [KEY_BYTES_W-1:0] pos_inc;
  logic                   top_bit;
  logic [KeyW-1:0]        rot_key;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign s_hs          = s_axis_tvalid && s_axis_tready;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_value_q <= '0;
      key_bytes_q <= KEY_BYTES_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_KEY_VALUE: key_value_q <= cfg_data_i[KeyW-1:0];
        REG_KEY_BYTES: key_bytes_q <= cfg_data_i[KEY_BYTES_W-1:0];
        default:       key_value_q <= key_value_q;
      endcase
    end
  end

  // Clamp the key length into 1..MAX_KEY_BYTES.
  always_comb begin
    priority if (key_bytes_q == '0) begin
      len_eff = OneLen;
    end else if (key_bytes_q > MaxLen) begin
      len_eff = MaxLen;
    end else begin
      len_eff = key_bytes_q;
    end
  end

  always_comb begin
    for (int unsigned i = 0; i < MAX_KEY_BYTES; i++) begin
      len_mask[BYTE_W*i +: BYTE_W] = (KEY_BYTES_W'(i) < len_eff) ? BYTE_MASK : '0;
    end
  end

  // Reload on first byte, then pick the key byte and rotate at block end.
  always_comb begin
    cur_key = s_axis_tuser ? (key_value_q & len_mask) : running_key_q;
    cur_pos = s_axis_tuser ? '0 : pos_q;
    pos_inc = KEY_BYTES_W'(cur_pos) + OneLen;

    top_bit = 1'b0;
    for (int unsigned i = 0; i < MAX_KEY_BYTES; i++) begin
      if (len_eff == KEY_BYTES_W'(i + 1)) begin
        top_bit = cur_key[BYTE_W*i + BYTE_W - 1];
      end
    end
    rot_key = ({cur_key[KeyW-2:0], 1'b0} | KeyW'(top_bit)) & len_mask;

    out_data_d = s_axis_tdata ^ cur_key[BYTE_W*cur_pos +: BYTE_W];

    if (pos_inc >= len_eff) begin
      running_key_d = rot_key;
      pos_d         = '0;
    end else begin
      running_key_d = cur_key;
      pos_d         = PosW'(pos_inc);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_key_q <= '0;
      pos_q         <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      if (s_hs) begin
        running_key_q <= running_key_d;
        pos_q         <= pos_d;
        out_valid_q   <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q   <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_hs) begin
      out_data_q <= out_data_d;
      out_last_q <= s_axis_tlast;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;

  `XCRK_ASSERT(a_accept_fills_output, s_hs |=> out_valid_q)
  `XCRK_ASSERT(a_no_overwrite, s_hs |-> !(out_valid_q && !m_axis_tready))
  `XCRK_ASSERT(a_first_resets_pos,
    (s_hs && s_axis_tuser && len_eff > OneLen) |=> pos_q == PosW'(1))
  `XCRK_ASSERT(a_key_holds_midblock,
    (s_hs && !s_axis_tuser && pos_inc < len_eff) |=> $stable(running_key_q))

endmodule

// ----- test/tb_top.sv -----
// Self-checking testbench for the rotating-key XOR byte cipher.
`timescale 1ns / 1ps

module tb_top;
  import xcrk_pkg::*;

  typedef struct packed {
    logic [7:0] plain;
    logic       first;
    logic       last;
  } byte_req_t;

  typedef struct packed {
    logic [7:0] cipher;
    logic       eom;
  } cipher_res_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic                  cfg_idx_i = 1'b0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [BYTE_W-1:0]     s_axis_tdata = '0;  // [7:0] plain_byte
  logic                  s_axis_tuser = 1'b0;  // [0] first_of_message
  logic                  s_axis_tlast = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [BYTE_W-1:0]     m_axis_tdata;   // [7:0] cipher_byte
  logic                  m_axis_tlast;

  xor_cipher_rotating_key dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  byte_req_t   pending_bytes[$];
  cipher_res_t expected_cipher[$];
  byte_req_t   cur_req;

  logic [63:0] key_val = '0;
  logic [3:0]  key_len_q = KEY_BYTES_RST;
  logic [63:0] run_key = '0;
  logic [2:0]  key_pos = '0;

  bit quiet = 1'b0;
  bit hold_done = 1'b0;
  int gap_cnt = 0;
  int stall_cnt = 0;
  int hold_cnt = 0;
  int results_seen = 0;
  int mismatches = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic cipher_res_t encrypt_byte(input logic [7:0] plain, input logic first,
                                               input logic last);
    int unsigned len;
    logic [63:0] mask;
    logic [63:0] rk;
    cipher_res_t res;
    len = key_len_q;
    if (len < 1) len = 1;
    if (len > 8) len = 8;
    mask = (len == 8) ? '1 : ((64'd1 << (8 * len)) - 64'd1);
    if (first) begin
      run_key = key_val & mask;
      key_pos = '0;
    end
    res.cipher = plain ^ run_key[8*key_pos +: 8];
    res.eom    = last;
    if (key_pos + 1 >= len) begin
      rk      = run_key & mask;
      run_key = ((rk << 1) | ((rk >> (8 * len - 1)) & 64'd1)) & mask;
      key_pos = '0;
    end else begin
      key_pos = key_pos + 3'd1;
    end
    return res;
  endfunction

  // Driver: record each accepted request, then offer the next one.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready)
        expected_cipher.push_back(encrypt_byte(cur_req.plain, cur_req.first, cur_req.last));
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_cnt > 0) begin
          gap_cnt--;
          s_axis_tvalid <= 1'b0;
        end else if (!quiet && pending_bytes.size() != 0 && $urandom_range(0, 5) == 0) begin
          gap_cnt = $urandom_range(0, 3);
          s_axis_tvalid <= 1'b0;
        end else if (pending_bytes.size() != 0) begin
          cur_req = pending_bytes.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= cur_req.plain;
          s_axis_tuser  <= cur_req.first;
          s_axis_tlast  <= cur_req.last;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each result with the oldest expectation, and apply back-pressure.
  always @(posedge clk_i) begin
    cipher_res_t exp_res;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_cipher.size() == 0) begin
          $error("unexpected result: cipher_byte %h, end_of_message %b",
                 m_axis_tdata, m_axis_tlast);
          mismatches++;
        end else begin
          exp_res = expected_cipher.pop_front();
          if (m_axis_tdata !== exp_res.cipher) begin
            $error("cipher_byte: expected %h, actual %h", exp_res.cipher, m_axis_tdata);
            mismatches++;
          end
          if (m_axis_tlast !== exp_res.eom) begin
            $error("end_of_message: expected %b, actual %b", exp_res.eom, m_axis_tlast);
            mismatches++;
          end
        end
        results_seen++;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        m_axis_tready <= 1'b0;
      end else if (!hold_done && results_seen >= 300) begin
        hold_done = 1'b1;
        hold_cnt  = 48;
        m_axis_tready <= 1'b0;
      end else if (stall_cnt > 0) begin
        stall_cnt--;
        m_axis_tready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 6) == 0) begin
        stall_cnt = $urandom_range(0, 3);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  task automatic write_reg(input cfg_reg_e idx, input logic [63:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_KEY_VALUE) key_val = val;
    else key_len_q = val[3:0];
  endtask

  task automatic push_byte(input logic [7:0] plain, input logic first, input logic last);
    byte_req_t r;
    r.plain = plain;
    r.first = first;
    r.last  = last;
    pending_bytes.push_back(r);
  endtask

  task automatic queue_message(input int unsigned nbytes, input bit with_first);
    for (int unsigned i = 0; i < nbytes; i++)
      push_byte(8'($urandom_range(0, 255)), with_first && i == 0, i == nbytes - 1);
  endtask

  task automatic drain();
    while (pending_bytes.size() != 0 || s_axis_tvalid || expected_cipher.size() != 0)
      @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  initial begin
    int unsigned n;
    int unsigned sent;
    int unsigned kind;
    logic [3:0]  len;
    logic [63:0] key;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Running key is zero after reset: bytes pass unchanged.
    push_byte(8'h00, 1'b0, 1'b0);
    push_byte(8'hFF, 1'b0, 1'b0);
    push_byte(8'h5A, 1'b0, 1'b1);
    drain();

    write_reg(REG_KEY_VALUE, 64'hFFFF_FFFF_FFFF_FFFF);
    for (int i = 0; i < 9; i++)
      push_byte((i % 2) ? 8'hFF : 8'h00, i == 0, i == 8);
    drain();

    // Zero key length acts as one byte.
    write_reg(REG_KEY_BYTES, 64'd0);
    write_reg(REG_KEY_VALUE, 64'h0000_0000_0000_0081);
    push_byte(8'h00, 1'b1, 1'b0);
    push_byte(8'h00, 1'b0, 1'b0);
    push_byte(8'hFF, 1'b0, 1'b1);
    drain();

    // Key length above the maximum acts as the maximum; leave the message open.
    write_reg(REG_KEY_BYTES, 64'd15);
    write_reg(REG_KEY_VALUE, 64'h8000_0000_0000_0001);
    push_byte(8'h00, 1'b1, 1'b0);
    push_byte(8'h00, 1'b0, 1'b0);
    drain();

    // Shrink the key length mid-message, then end on a partial block.
    write_reg(REG_KEY_BYTES, 64'd3);
    push_byte(8'h00, 1'b0, 1'b0);
    push_byte(8'h00, 1'b0, 1'b0);
    push_byte(8'h00, 1'b0, 1'b0);
    push_byte(8'hFF, 1'b1, 1'b0);
    push_byte(8'hFF, 1'b0, 1'b0);
    push_byte(8'hFF, 1'b0, 1'b0);
    push_byte(8'hFF, 1'b0, 1'b0);
    push_byte(8'hFF, 1'b0, 1'b1);
    drain();

    for (int ph = 0; ph < 10; ph++) begin
      if (ph == 9) quiet = 1'b1;
      case ($urandom_range(0, 5))
        0: len = 4'd1;
        1: len = 4'd8;
        2: len = 4'd0;
        3: len = 4'd15;
        default: len = 4'($urandom_range(0, 15));
      endcase
      if (ph == 1) key = '0;
      else if (ph == 2) key = '1;
      else key = {$urandom, $urandom};
      write_reg(REG_KEY_BYTES, {60'd0, len});
      if (ph % 4 != 3) write_reg(REG_KEY_VALUE, key);
      sent = 0;
      while (sent < 120) begin
        kind = $urandom_range(0, 9);
        if (kind < 8) begin
          n = $urandom_range(1, 20);
          queue_message(n, 1'b1);
        end else if (kind == 8) begin
          n = $urandom_range(1, 6);
          queue_message(n, 1'b0);
        end else begin
          n = $urandom_range(1, 8);
          for (int unsigned i = 0; i < n; i++)
            push_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)));
        end
        sent += n;
      end
      drain();
    end

    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/xcrk_pkg.sv
rtl/xor_cipher_rotating_key.sv
test/tb_top.sv
